// File: hdl/touch_tap_long_press_classifier_defines.svh
// ----------------------------------------------------------------------------
// touch tap / long-press classifier check macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TOUCH_TAP_LONG_PRESS_CLASSIFIER_DEFINES_SVH
`define TOUCH_TAP_LONG_PRESS_CLASSIFIER_DEFINES_SVH

// generic clocked check with a fixed message
`define TTLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("touch classifier check failed");

// clocked check with a caller supplied message
`define TTLP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// File: hdl/ttlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_pkg
// shared types, codes and helpers of the touch tap / long-press classifier
// ----------------------------------------------------------------------------
package ttlp_pkg;

  localparam int TICK_MS_DEF    = 40;
  localparam int COORD_BITS_DEF = 10;
  localparam int TIMER_W        = 16;
  localparam int MIDLINE_W      = 10;
  localparam int TOL_W          = 8;
  localparam int REG_IDX_W      = 3;
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;
  localparam int OUT_DATA_W     = 8;

  localparam logic [MIDLINE_W-1:0] MIDLINE_RST  = 10'd400;
  localparam logic [TOL_W-1:0]     MOVE_TOL_RST = 8'd8;
  localparam logic [TIMER_W-1:0]   STABLE_RST   = 16'd50;
  localparam logic [TIMER_W-1:0]   RELEASE_RST  = 16'd150;
  localparam logic [TIMER_W-1:0]   LONG_RST     = 16'd1500;
  localparam logic [TIMER_W-1:0]   DEBOUNCE_RST = 16'd180;
  localparam logic [TIMER_W-1:0]   PWR_HOLD_RST = 16'd3000;
  localparam logic [TIMER_W-1:0]   TIMEOUT_RST  = 16'd60000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIDLINE_X  = 3'd0,
    REG_MOVE_TOL   = 3'd1,
    REG_STABLE     = 3'd2,
    REG_RELEASE    = 3'd3,
    REG_LONG_PRESS = 3'd4,
    REG_DEBOUNCE   = 3'd5,
    REG_POWER_HOLD = 3'd6,
    REG_TIMEOUT    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_PREV  = 3'd1,
    ACT_NEXT  = 3'd2,
    ACT_FIRST = 3'd3,
    ACT_FINAL = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    PH_WAIT_REL = 3'd0,
    PH_IDLE     = 3'd1,
    PH_QUALIFY  = 3'd2,
    PH_HOLD     = 3'd3,
    PH_RELEASE  = 3'd4,
    PH_DEBOUNCE = 3'd5
  } phase_t;

  typedef struct packed {
    logic [MIDLINE_W-1:0] midline_x;
    logic [TOL_W-1:0]     move_tolerance;
    logic [TIMER_W-1:0]   stable_time_ms;
    logic [TIMER_W-1:0]   release_time_ms;
    logic [TIMER_W-1:0]   long_press_ms;
    logic [TIMER_W-1:0]   debounce_ms;
    logic [TIMER_W-1:0]   power_hold_ms;
    logic [TIMER_W-1:0]   nav_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    action_t action;
  } nav_res_t;

  // timer advance by one tick, held at all ones
  function automatic logic [TIMER_W-1:0] sat_tick(input logic [TIMER_W-1:0] t,
                                                  input logic [TIMER_W-1:0] step);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + {1'b0, step};
    return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

endpackage

// File: hdl/ttlp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_cfg_regs
// apb register bank holding the thresholds and times of the classifier
// ----------------------------------------------------------------------------
module ttlp_cfg_regs
  import ttlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.midline_x       <= MIDLINE_RST;
      cfg_r.move_tolerance  <= MOVE_TOL_RST;
      cfg_r.stable_time_ms  <= STABLE_RST;
      cfg_r.release_time_ms <= RELEASE_RST;
      cfg_r.long_press_ms   <= LONG_RST;
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.power_hold_ms   <= PWR_HOLD_RST;
      cfg_r.nav_timeout_ms  <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIDLINE_X:  cfg_r.midline_x       <= pwdata[MIDLINE_W-1:0];
        REG_MOVE_TOL:   cfg_r.move_tolerance  <= pwdata[TOL_W-1:0];
        REG_STABLE:     cfg_r.stable_time_ms  <= pwdata[TIMER_W-1:0];
        REG_RELEASE:    cfg_r.release_time_ms <= pwdata[TIMER_W-1:0];
        REG_LONG_PRESS: cfg_r.long_press_ms   <= pwdata[TIMER_W-1:0];
        REG_DEBOUNCE:   cfg_r.debounce_ms     <= pwdata[TIMER_W-1:0];
        REG_POWER_HOLD: cfg_r.power_hold_ms   <= pwdata[TIMER_W-1:0];
        REG_TIMEOUT:    cfg_r.nav_timeout_ms  <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIDLINE_X:  prdata = APB_DATA_W'(cfg_r.midline_x);
      REG_MOVE_TOL:   prdata = APB_DATA_W'(cfg_r.move_tolerance);
      REG_STABLE:     prdata = APB_DATA_W'(cfg_r.stable_time_ms);
      REG_RELEASE:    prdata = APB_DATA_W'(cfg_r.release_time_ms);
      REG_LONG_PRESS: prdata = APB_DATA_W'(cfg_r.long_press_ms);
      REG_DEBOUNCE:   prdata = APB_DATA_W'(cfg_r.debounce_ms);
      REG_POWER_HOLD: prdata = APB_DATA_W'(cfg_r.power_hold_ms);
      REG_TIMEOUT:    prdata = APB_DATA_W'(cfg_r.nav_timeout_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hdl/ttlp_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_power
// power button hold detector, one pulse when the hold runs past its limit
// ----------------------------------------------------------------------------
module ttlp_power
  import ttlp_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [TIMER_W-1:0] power_hold_ms,
  input  logic               power_pressed,
  output logic               power_off
);

  localparam logic [TIMER_W-1:0] TICK = TIMER_W'(TICK_MS);

  logic [TIMER_W-1:0] timer_r, timer_nxt, timer_inc;
  logic               seen_r, seen_nxt;

  always_comb begin
    timer_inc = sat_tick(timer_r, TICK);
    timer_nxt = timer_r;
    seen_nxt  = seen_r;
    power_off = 1'b0;
    if (!power_pressed) begin
      seen_nxt  = 1'b0;
      timer_nxt = '0;
    end else if (!seen_r) begin
      // first pressed sample only arms the timer
      seen_nxt  = 1'b1;
      timer_nxt = '0;
    end else if (timer_inc > power_hold_ms) begin
      power_off = 1'b1;
      seen_nxt  = 1'b0;
      timer_nxt = '0;
    end else begin
      timer_nxt = timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      seen_r  <= 1'b0;
    end else if (en) begin
      timer_r <= timer_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// File: hdl/ttlp_nav.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_nav
// navigation gesture sequencer: release wait, qualify, hold, debounce, report
// ----------------------------------------------------------------------------
module ttlp_nav
  import ttlp_pkg::*;
#(
  parameter int TICK_MS    = TICK_MS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cfg_t                  cfg,
  input  logic                  touch_down,
  input  logic [COORD_BITS-1:0] touch_x,
  input  logic [COORD_BITS-1:0] touch_y,
  output nav_res_t              res
);

  localparam logic [TIMER_W-1:0] TICK = TIMER_W'(TICK_MS);
  localparam int CMP_W = (COORD_BITS > MIDLINE_W) ? COORD_BITS : MIDLINE_W;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_W-1:0]    pt_r, pt_nxt, win_r, win_nxt, ht_r, ht_nxt;
  logic [COORD_BITS-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic                  left_r, left_nxt;

  function automatic action_t classify(input logic [TIMER_W-1:0] hold,
                                       input logic [TIMER_W-1:0] long_ms,
                                       input logic left);
    if (hold >= long_ms) return left ? ACT_FIRST : ACT_FINAL;
    return left ? ACT_PREV : ACT_NEXT;
  endfunction

  always_comb begin
    logic [TIMER_W-1:0]    pt_inc, ht_inc, rel_start;
    logic [COORD_BITS-1:0] dx, dy, tol;
    logic                  count_win;
    pt_inc    = sat_tick(pt_r, TICK);
    ht_inc    = sat_tick(ht_r, TICK);
    dx        = (touch_x > ax_r) ? touch_x - ax_r : ax_r - touch_x;
    dy        = (touch_y > ay_r) ? touch_y - ay_r : ay_r - touch_y;
    tol       = COORD_BITS'(cfg.move_tolerance);
    rel_start = (phase_r == PH_HOLD) ? '0 : pt_r;
    count_win = 1'b0;
    phase_nxt = phase_r;
    pt_nxt    = pt_r;
    win_nxt   = win_r;
    ht_nxt    = ht_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    left_nxt  = left_r;
    res       = '{valid: 1'b0, action: ACT_NONE};
    unique case (phase_r)
      PH_IDLE: begin
        if (win_r >= cfg.nav_timeout_ms) begin
          res.valid = 1'b1;
          phase_nxt = PH_WAIT_REL;
          pt_nxt    = '0;
          win_nxt   = '0;
          ht_nxt    = '0;
        end else begin
          count_win = 1'b1;
          if (touch_down) begin
            ax_nxt = touch_x;
            ay_nxt = touch_y;
            pt_nxt = '0;
            if (cfg.stable_time_ms == '0) begin
              left_nxt  = CMP_W'(touch_x) < CMP_W'(cfg.midline_x);
              ht_nxt    = '0;
              phase_nxt = PH_HOLD;
            end else begin
              phase_nxt = PH_QUALIFY;
            end
          end
        end
      end
      PH_QUALIFY: begin
        count_win = 1'b1;
        if (!touch_down || dx > tol || dy > tol) begin
          phase_nxt = PH_IDLE;
          pt_nxt    = '0;
        end else if (pt_inc >= cfg.stable_time_ms) begin
          left_nxt  = CMP_W'(ax_r) < CMP_W'(cfg.midline_x);
          ht_nxt    = '0;
          pt_nxt    = '0;
          phase_nxt = PH_HOLD;
        end else begin
          pt_nxt = pt_inc;
        end
      end
      PH_HOLD, PH_RELEASE: begin
        ht_nxt = ht_inc;
        if (!(phase_r == PH_HOLD && touch_down)) begin
          phase_nxt = PH_RELEASE;
          if (touch_down) begin
            pt_nxt = '0;
          end else if (rel_start >= cfg.release_time_ms) begin
            pt_nxt = '0;
            if (cfg.debounce_ms == '0) begin
              res.valid  = 1'b1;
              res.action = classify(ht_inc, cfg.long_press_ms, left_r);
              phase_nxt  = PH_WAIT_REL;
              win_nxt    = '0;
              ht_nxt     = '0;
            end else begin
              phase_nxt = PH_DEBOUNCE;
            end
          end else begin
            pt_nxt = sat_tick(rel_start, TICK);
          end
        end
      end
      PH_DEBOUNCE: begin
        ht_nxt = ht_inc;
        pt_nxt = pt_inc;
        if (pt_inc >= cfg.debounce_ms) begin
          res.valid  = 1'b1;
          res.action = classify(ht_inc, cfg.long_press_ms, left_r);
          phase_nxt  = PH_WAIT_REL;
          pt_nxt     = '0;
          win_nxt    = '0;
          ht_nxt     = '0;
        end
      end
      default: begin
        // initial release wait, also taken for any stray phase code
        phase_nxt = PH_WAIT_REL;
        count_win = 1'b1;
        if (touch_down) begin
          pt_nxt = '0;
        end else if (pt_r >= cfg.release_time_ms) begin
          phase_nxt = PH_IDLE;
          pt_nxt    = '0;
        end else begin
          pt_nxt = pt_inc;
        end
      end
    endcase
    if (count_win) win_nxt = sat_tick(win_r, TICK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_REL;
      pt_r    <= '0;
      win_r   <= '0;
      ht_r    <= '0;
      ax_r    <= '0;
      ay_r    <= '0;
      left_r  <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      pt_r    <= pt_nxt;
      win_r   <= win_nxt;
      ht_r    <= ht_nxt;
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: hdl/touch_tap_long_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_long_press_classifier
// tap / long-press navigation classifier with power-hold detector
// ----------------------------------------------------------------------------
// One touch and power sample is taken per poll tick on the in_ stream and the
// block accepts a sample in every clock cycle while in_tready is high. A
// sample goes into an input register, the gesture sequencer and the power
// detector update their state from it in one pass, and when the sample moves
// on its result is registered in the output register. A result is sent only
// for a sample that reports a navigation decision or a power-off pulse; other
// samples produce nothing on out_. in_tready drops only while both the input
// and output registers are full and out_tready is low. Configuration is taken
// over the apb port and should be changed only while no sample is in flight.
// ----------------------------------------------------------------------------
`include "touch_tap_long_press_classifier_defines.svh"

module touch_tap_long_press_classifier
  import ttlp_pkg::*;
#(
  parameter int TICK_MS    = TICK_MS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_FLD_W  = 2 * COORD_BITS + 2,
  localparam int IN_DATA_W = ((IN_FLD_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: touch_down, touch_x, touch_y, power_pressed, zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: action_valid, action[2:0], power_off, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                  cfg;
  logic [IN_FLD_W-1:0]   in_r;
  logic                  in_vld_r;
  logic                  adv;
  logic                  power_off;
  nav_res_t              nav_res;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_r;
  logic                  res_any;

  assign cfg_pready = 1'b1;

  ttlp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // the held sample moves on when the output register is free or draining
  assign adv       = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_r <= in_tdata[IN_FLD_W-1:0];
  end

  ttlp_nav #(
    .TICK_MS    (TICK_MS),
    .COORD_BITS (COORD_BITS)
  ) u_nav (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .cfg        (cfg),
    .touch_down (in_r[0]),
    .touch_x    (in_r[COORD_BITS:1]),
    .touch_y    (in_r[2*COORD_BITS:COORD_BITS+1]),
    .res        (nav_res)
  );

  ttlp_power #(
    .TICK_MS (TICK_MS)
  ) u_power (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .power_hold_ms (cfg.power_hold_ms),
    .power_pressed (in_r[IN_FLD_W-1]),
    .power_off     (power_off)
  );

  assign res_any = nav_res.valid | power_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_any;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_any) begin
      out_r <= OUT_DATA_W'({power_off, nav_res.action, nav_res.valid});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // no empty transfer leaves the block
  `TTLP_ASSERT(a_out_not_empty, out_tvalid |-> (out_tdata[0] || out_tdata[4]))
  // a power-only result carries the none code
  `TTLP_ASSERT(a_action_none, (out_tvalid && !out_tdata[0]) |-> (out_tdata[3:1] == ACT_NONE))
  // action code stays within the defined set
  `TTLP_ASSERT_MSG(a_action_range, out_tvalid |-> (out_tdata[3:1] <= ACT_FINAL),
    "action code out of range")
  // input backpressure only comes from a stalled output
  `TTLP_ASSERT_MSG(a_ready_cause, !in_tready |-> (out_tvalid && !out_tready),
    "input stalled without output stall")

endmodule
